@@ src/cqs_pkg.sv @@
// Shared constants and types for the circular queue with search.
`timescale 1ns / 1ps

package cqs_pkg;

    localparam int DEPTH       = 16;
    localparam int DATA_WIDTH  = 32;
    localparam int IDX_W       = $clog2(DEPTH);
    localparam int CAP_W       = $clog2(DEPTH + 1);
    localparam int POS_W       = $clog2(DEPTH + 1);
    localparam int FUNC_W      = 2;
    localparam int STATUS_W    = 3;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + POS_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - DATA_WIDTH - POS_W;

    localparam logic [FUNC_W-1:0] FUNC_INSERT = 2'd0;
    localparam logic [FUNC_W-1:0] FUNC_DELETE = 2'd1;
    localparam logic [FUNC_W-1:0] FUNC_SEARCH = 2'd2;

    localparam logic [STATUS_W-1:0] STAT_DONE    = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_FULL    = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_EMPTY   = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_MATCH   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_NOMATCH = 3'd4;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DEL,
        ST_SRCH,
        ST_FLUSH
    } state_t;

endpackage

@@ src/cqs_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module cqs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

@@ src/circular_queue_with_search.sv @@
// Circular FIFO queue of signed words with insert, delete and search.
//
//  channel   | handshake                      | payload
//  ----------+--------------------------------+-------------------------------------
//  cfg       | cfg_valid / cfg_ready          | cfg_data: capacity
//  s_axis    | s_axis_tvalid / s_axis_tready  | tuser: func, tdata: value
//  m_axis    | m_axis_tvalid / m_axis_tready  | tuser: status, tdata: data, position,
//            |                                | tlast: last
//
// Insert and func 3 answer directly; delete goes through ST_DEL (one RAM read).
// Search reads one entry per cycle through the single RAM read port while
// the output is free; the final match is sent from ST_FLUSH.
// A stalled output holds the walk on the current entry.
// Reset: empty queue, capacity 16; a capacity write also empties the queue.
`timescale 1ns / 1ps

module circular_queue_with_search (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [cqs_pkg::CAP_W-1:0]             cfg_data,
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [cqs_pkg::DATA_WIDTH-1:0]        s_axis_tdata,   // value
    input  logic [cqs_pkg::FUNC_W-1:0]            s_axis_tuser,   // func
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [cqs_pkg::OUT_TDATA_W-1:0]       m_axis_tdata,   // data, position, zero pad
    output logic [cqs_pkg::STATUS_W-1:0]          m_axis_tuser,   // status
    output logic                                  m_axis_tlast
);

    cqs_pkg::state_t state_reg, state_next;

    logic [cqs_pkg::CAP_W-1:0]      cap_reg, cap_next, cap_eff;
    logic [cqs_pkg::IDX_W-1:0]      head_reg, head_next;
    logic [cqs_pkg::IDX_W-1:0]      tail_reg, tail_next;
    logic                           holds_reg, holds_next;
    logic [cqs_pkg::DATA_WIDTH-1:0] key_reg, key_next;
    logic [cqs_pkg::IDX_W-1:0]      idx_reg, idx_next;
    logic [cqs_pkg::POS_W-1:0]      pos_reg, pos_next;
    logic                           pend_v_reg, pend_v_next;
    logic [cqs_pkg::DATA_WIDTH-1:0] pend_data_reg, pend_data_next;
    logic [cqs_pkg::POS_W-1:0]      pend_pos_reg, pend_pos_next;
    logic                           out_v_reg, out_v_next;
    logic [cqs_pkg::STATUS_W-1:0]   out_status_reg, out_status_next;
    logic [cqs_pkg::DATA_WIDTH-1:0] out_data_reg, out_data_next;
    logic [cqs_pkg::POS_W-1:0]      out_pos_reg, out_pos_next;
    logic                           out_last_reg, out_last_next;

    logic                           ram_we;
    logic [cqs_pkg::IDX_W-1:0]      ram_waddr, ram_raddr;
    logic [cqs_pkg::DATA_WIDTH-1:0] ram_rdata;

    logic                           out_free, accept, cfg_wr;
    logic                           match, at_end, stall;
    logic [cqs_pkg::IDX_W-1:0]      tail_adv;

    function automatic logic [cqs_pkg::IDX_W-1:0] ring_next(
        input logic [cqs_pkg::IDX_W-1:0] i,
        input logic [cqs_pkg::CAP_W-1:0] cap
    );
        logic [cqs_pkg::CAP_W-1:0] n;
        n = cqs_pkg::CAP_W'(i) + cqs_pkg::CAP_W'(1);
        ring_next = (n >= cap) ? '0 : n[cqs_pkg::IDX_W-1:0];
    endfunction

    always_comb
    begin
        if (cap_reg == '0)
        begin
            cap_eff = cqs_pkg::CAP_W'(1);
        end
        else if (cap_reg > cqs_pkg::CAP_W'(cqs_pkg::DEPTH))
        begin
            cap_eff = cqs_pkg::CAP_W'(cqs_pkg::DEPTH);
        end
        else
        begin
            cap_eff = cap_reg;
        end
    end

    assign cfg_ready     = 1'b1;
    assign cfg_wr        = cfg_valid && cfg_ready;
    assign out_free      = !out_v_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == cqs_pkg::ST_IDLE) && out_free;
    assign accept        = s_axis_tvalid && s_axis_tready;

    assign match    = (ram_rdata == key_reg);
    assign at_end   = (idx_reg == tail_reg);
    assign stall    = !out_free && ((match && pend_v_reg) || (at_end && !match && !pend_v_reg));
    assign tail_adv = ring_next(tail_reg, cap_eff);

    assign ram_raddr = (state_reg == cqs_pkg::ST_SRCH) ? idx_next : head_reg;

    cqs_ram #(
        .WIDTH (cqs_pkg::DATA_WIDTH),
        .DEPTH (cqs_pkg::DEPTH)
    ) u_slots (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (s_axis_tdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            cqs_pkg::ST_IDLE:
            begin
                if (accept && holds_reg &&
                    (s_axis_tuser == cqs_pkg::FUNC_DELETE))
                begin
                    state_next = cqs_pkg::ST_DEL;
                end
                else if (accept && holds_reg &&
                         (s_axis_tuser == cqs_pkg::FUNC_SEARCH))
                begin
                    state_next = cqs_pkg::ST_SRCH;
                end
            end
            cqs_pkg::ST_DEL:
            begin
                state_next = cqs_pkg::ST_IDLE;
            end
            cqs_pkg::ST_SRCH:
            begin
                if (!stall && at_end)
                begin
                    state_next = (match || pend_v_reg) ? cqs_pkg::ST_FLUSH : cqs_pkg::ST_IDLE;
                end
            end
            cqs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    state_next = cqs_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = cqs_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cap_next        = cap_reg;
        head_next       = head_reg;
        tail_next       = tail_reg;
        holds_next      = holds_reg;
        key_next        = key_reg;
        idx_next        = idx_reg;
        pos_next        = pos_reg;
        pend_v_next     = pend_v_reg;
        pend_data_next  = pend_data_reg;
        pend_pos_next   = pend_pos_reg;
        out_v_next      = out_v_reg && !m_axis_tready;
        out_status_next = out_status_reg;
        out_data_next   = out_data_reg;
        out_pos_next    = out_pos_reg;
        out_last_next   = out_last_reg;
        ram_we          = 1'b0;
        ram_waddr       = tail_adv;

        unique case (state_reg)
            cqs_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    out_v_next      = 1'b1;
                    out_status_next = cqs_pkg::STAT_DONE;
                    out_data_next   = '0;
                    out_pos_next    = '0;
                    out_last_next   = 1'b1;
                    unique case (s_axis_tuser)
                        cqs_pkg::FUNC_INSERT:
                        begin
                            if (!holds_reg)
                            begin
                                ram_we     = 1'b1;
                                ram_waddr  = '0;
                                head_next  = '0;
                                tail_next  = '0;
                                holds_next = 1'b1;
                            end
                            else if (tail_adv == head_reg)
                            begin
                                out_status_next = cqs_pkg::STAT_FULL;
                            end
                            else
                            begin
                                ram_we    = 1'b1;
                                tail_next = tail_adv;
                            end
                        end
                        cqs_pkg::FUNC_DELETE:
                        begin
                            if (!holds_reg)
                            begin
                                out_status_next = cqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_v_next = 1'b0;
                                if (head_reg == tail_reg)
                                begin
                                    head_next  = '0;
                                    tail_next  = '0;
                                    holds_next = 1'b0;
                                end
                                else
                                begin
                                    head_next = ring_next(head_reg, cap_eff);
                                end
                            end
                        end
                        cqs_pkg::FUNC_SEARCH:
                        begin
                            if (!holds_reg)
                            begin
                                out_status_next = cqs_pkg::STAT_EMPTY;
                            end
                            else
                            begin
                                out_v_next  = 1'b0;
                                key_next    = s_axis_tdata;
                                idx_next    = head_reg;
                                pos_next    = cqs_pkg::POS_W'(1);
                                pend_v_next = 1'b0;
                            end
                        end
                        default:
                        begin
                            out_status_next = cqs_pkg::STAT_DONE;
                        end
                    endcase
                end
            end
            cqs_pkg::ST_DEL:
            begin
                out_v_next      = 1'b1;
                out_status_next = cqs_pkg::STAT_DONE;
                out_data_next   = ram_rdata;
                out_pos_next    = '0;
                out_last_next   = 1'b1;
            end
            cqs_pkg::ST_SRCH:
            begin
                if (!stall)
                begin
                    if (match && pend_v_reg)
                    begin
                        out_v_next      = 1'b1;
                        out_status_next = cqs_pkg::STAT_MATCH;
                        out_data_next   = pend_data_reg;
                        out_pos_next    = pend_pos_reg;
                        out_last_next   = 1'b0;
                    end
                    if (match)
                    begin
                        pend_v_next    = 1'b1;
                        pend_data_next = ram_rdata;
                        pend_pos_next  = pos_reg;
                    end
                    if (at_end)
                    begin
                        if (!match && !pend_v_reg)
                        begin
                            out_v_next      = 1'b1;
                            out_status_next = cqs_pkg::STAT_NOMATCH;
                            out_data_next   = '0;
                            out_pos_next    = '0;
                            out_last_next   = 1'b1;
                        end
                    end
                    else
                    begin
                        idx_next = ring_next(idx_reg, cap_eff);
                        pos_next = pos_reg + cqs_pkg::POS_W'(1);
                    end
                end
            end
            cqs_pkg::ST_FLUSH:
            begin
                if (out_free)
                begin
                    out_v_next      = 1'b1;
                    out_status_next = cqs_pkg::STAT_MATCH;
                    out_data_next   = pend_data_reg;
                    out_pos_next    = pend_pos_reg;
                    out_last_next   = 1'b1;
                    pend_v_next     = 1'b0;
                end
            end
            default:
            begin
                out_v_next = out_v_reg && !m_axis_tready;
            end
        endcase

        if (cfg_wr)
        begin
            cap_next   = cfg_data;
            head_next  = '0;
            tail_next  = '0;
            holds_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= cqs_pkg::ST_IDLE;
            cap_reg    <= cqs_pkg::CAP_W'(cqs_pkg::DEPTH);
            head_reg   <= '0;
            tail_reg   <= '0;
            holds_reg  <= 1'b0;
            pend_v_reg <= 1'b0;
            out_v_reg  <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            cap_reg    <= cap_next;
            head_reg   <= head_next;
            tail_reg   <= tail_next;
            holds_reg  <= holds_next;
            pend_v_reg <= pend_v_next;
            out_v_reg  <= out_v_next;
        end
    end

    always_ff @(posedge clk)
    begin
        key_reg        <= key_next;
        idx_reg        <= idx_next;
        pos_reg        <= pos_next;
        pend_data_reg  <= pend_data_next;
        pend_pos_reg   <= pend_pos_next;
        out_status_reg <= out_status_next;
        out_data_reg   <= out_data_next;
        out_pos_reg    <= out_pos_next;
        out_last_reg   <= out_last_next;
    end

    assign m_axis_tvalid = out_v_reg;
    assign m_axis_tuser  = out_status_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {{cqs_pkg::OUT_PAD_W{1'b0}}, out_pos_reg, out_data_reg};

endmodule

@@ src/cqs_checker.sv @@
// Port-level assertions for the circular queue with search, bound to the top level.
`timescale 1ns / 1ps

module cqs_checker (
    input logic                                  clk,
    input logic                                  rst_n,
    input logic                                  s_axis_tvalid,
    input logic                                  s_axis_tready,
    input logic [cqs_pkg::FUNC_W-1:0]            s_axis_tuser,
    input logic                                  m_axis_tvalid,
    input logic                                  m_axis_tready,
    input logic [cqs_pkg::STATUS_W-1:0]          m_axis_tuser,
    input logic                                  m_axis_tlast
);

    // result held until taken
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result dropped while stalled");

    // an insert answers on the next cycle with a single final item
    a_insert_resp: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready && (s_axis_tuser == cqs_pkg::FUNC_INSERT)
        |=> m_axis_tvalid && m_axis_tlast &&
            ((m_axis_tuser == cqs_pkg::STAT_DONE) || (m_axis_tuser == cqs_pkg::STAT_FULL)))
        else $error("insert response missing or malformed");

    // only a match may be followed by more items of the same op
    a_nonmatch_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser != cqs_pkg::STAT_MATCH) |-> m_axis_tlast)
        else $error("non-match result without tlast");

    // input taken only when the output register can be loaded
    a_ready_room: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tready && m_axis_tvalid |-> m_axis_tready)
        else $error("input ready while output is blocked");

endmodule

bind circular_queue_with_search cqs_checker u_cqs_checker (.*);
